>>> rtl/core/expiring_challenge_table_top_defines.svh
// assertion macros for the expiring challenge table
// used by expiring_challenge_table_top, no other dependencies
`ifndef EXPIRING_CHALLENGE_TABLE_TOP_DEFINES_SVH
`define EXPIRING_CHALLENGE_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ECT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ECT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ect_pkg.sv
// shared types and constants of the expiring challenge table
// no dependencies; used by every module of the block
package ect_pkg;

	localparam int DEF_ENTRIES      = 16;
	localparam int DEF_COOKIE_BITS  = 64;
	localparam int DEF_PAYLOAD_BITS = 64;

	localparam int ADDR_W   = 32;
	localparam int TIME_W   = 64;
	localparam int DATA_W   = 64;
	localparam int KEY_W    = 64;
	localparam int WINDOW_W = 32;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd30000;

	typedef enum logic [1:0] {
		ACT_ADD,
		ACT_REMOVE,
		ACT_REMOVE_ALL,
		ACT_FIND
	} ect_action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_DONE
	} ect_state_t;

	typedef struct packed {
		ect_action_t          action;
		logic [KEY_W-1:0]     cookie;
		logic [ADDR_W-1:0]    client_ip;
		logic [DATA_W-1:0]    challenge_data;
		logic [TIME_W-1:0]    now_ms;
	} ect_req_t;

	typedef struct packed {
		logic                 hit;
		logic [DATA_W-1:0]    found_data;
	} ect_rsp_t;

	// write-back decision from the scan unit
	typedef struct packed {
		logic wr_en;
		logic wr_clear;
		logic hit;
	} ect_wb_t;

endpackage

>>> rtl/core/ect_table.sv
// slot memory: time, cookie, address and payload of every slot
// one write port, one read port with registered read data; uses ect_pkg
module ect_table #(
	parameter int ENTRIES      = ect_pkg::DEF_ENTRIES,
	parameter int COOKIE_BITS  = ect_pkg::DEF_COOKIE_BITS,
	parameter int PAYLOAD_BITS = ect_pkg::DEF_PAYLOAD_BITS,
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [IDX_W-1:0]           wr_idx,
	input  logic [ect_pkg::TIME_W-1:0] wr_time,
	input  logic [COOKIE_BITS-1:0]     wr_cookie,
	input  logic [ect_pkg::ADDR_W-1:0] wr_addr,
	input  logic [PAYLOAD_BITS-1:0]    wr_payload,
	input  logic                       rd_en,
	input  logic [IDX_W-1:0]           rd_idx,
	output logic [ect_pkg::TIME_W-1:0] rd_time_q,
	output logic [COOKIE_BITS-1:0]     rd_cookie_q,
	output logic [ect_pkg::ADDR_W-1:0] rd_addr_q,
	output logic [PAYLOAD_BITS-1:0]    rd_payload_q
);
	import ect_pkg::*;

	logic [TIME_W-1:0]       mem_time    [ENTRIES];
	logic [COOKIE_BITS-1:0]  mem_cookie  [ENTRIES];
	logic [ADDR_W-1:0]       mem_addr    [ENTRIES];
	logic [PAYLOAD_BITS-1:0] mem_payload [ENTRIES];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_time[wr_idx]    <= wr_time;
			mem_cookie[wr_idx]  <= wr_cookie;
			mem_addr[wr_idx]    <= wr_addr;
			mem_payload[wr_idx] <= wr_payload;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_time_q    <= mem_time[rd_idx];
			rd_cookie_q  <= mem_cookie[rd_idx];
			rd_addr_q    <= mem_addr[rd_idx];
			rd_payload_q <= mem_payload[rd_idx];
		end
	end

endmodule

>>> rtl/core/ect_scan.sv
// scan unit: walks the slot read stream and tracks the slot each action needs
// fed by ect_table read data; uses ect_pkg
module ect_scan #(
	parameter int ENTRIES      = ect_pkg::DEF_ENTRIES,
	parameter int COOKIE_BITS  = ect_pkg::DEF_COOKIE_BITS,
	parameter int PAYLOAD_BITS = ect_pkg::DEF_PAYLOAD_BITS,
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  ect_pkg::ect_action_t         action,
	input  logic [COOKIE_BITS-1:0]       cookie,
	input  logic [ect_pkg::ADDR_W-1:0]   addr,
	input  logic [ect_pkg::TIME_W-1:0]   now_find,
	input  logic [ect_pkg::TIME_W-1:0]   now_add,
	input  logic [ect_pkg::WINDOW_W-1:0] window,
	input  logic                         rd_en,
	input  logic [IDX_W-1:0]             rd_idx,
	input  logic [ect_pkg::TIME_W-1:0]   rd_time,
	input  logic [COOKIE_BITS-1:0]       rd_cookie,
	input  logic [ect_pkg::ADDR_W-1:0]   rd_addr,
	input  logic [PAYLOAD_BITS-1:0]      rd_payload,
	output ect_pkg::ect_wb_t             wb,
	output logic [IDX_W-1:0]             tgt_idx,
	output logic [PAYLOAD_BITS-1:0]      found_data
);
	import ect_pkg::*;

	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;

	logic              am_found_q, fr_found_q, ck_found_q, fd_found_q;
	logic [IDX_W-1:0]  am_idx_q, fr_idx_q, ck_idx_q, old_idx_q;
	logic [TIME_W-1:0] old_time_q;
	logic [PAYLOAD_BITS-1:0] fd_data_q;

	logic [TIME_W-1:0] win_ext;
	logic [TIME_W-1:0] age_add;
	logic [TIME_W-1:0] age_find;
	logic              slot_live;
	logic              addr_eq, cookie_eq;
	logic              is_free, is_find;

	// read data lines up with its index in the cycle after the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx;
	end

	// per-slot tests
	always_comb begin
		win_ext   = TIME_W'(window);
		age_add   = now_add - rd_time;
		age_find  = now_find - rd_time;
		slot_live = (rd_time != '0);
		addr_eq   = (rd_addr == addr);
		cookie_eq = (rd_cookie == cookie);
		is_free   = !slot_live || (age_add > win_ext);
		is_find   = slot_live && cookie_eq && addr_eq && (age_find < win_ext);
	end

	// first-match flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			am_found_q <= 1'b0;
			fr_found_q <= 1'b0;
			ck_found_q <= 1'b0;
			fd_found_q <= 1'b0;
		end else if (start) begin
			am_found_q <= 1'b0;
			fr_found_q <= 1'b0;
			ck_found_q <= 1'b0;
			fd_found_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (addr_eq) am_found_q <= 1'b1;
			if (is_free) fr_found_q <= 1'b1;
			if (slot_live && cookie_eq) ck_found_q <= 1'b1;
			if (is_find) fd_found_q <= 1'b1;
		end
	end

	// tracked indexes, oldest time and found payload
	always_ff @(posedge clk) begin
		if (start) begin
			fd_data_q <= '0;
		end else if (rd_vld_s1) begin
			if (!am_found_q && addr_eq) am_idx_q <= rd_idx_s1;
			if (!fr_found_q && is_free) fr_idx_q <= rd_idx_s1;
			if (!ck_found_q && slot_live && cookie_eq) ck_idx_q <= rd_idx_s1;
			if (!fd_found_q && is_find) fd_data_q <= rd_payload;
			// strict compare keeps the first of equal oldest slots
			if (rd_idx_s1 == '0 || rd_time < old_time_q) begin
				old_time_q <= rd_time;
				old_idx_q  <= rd_idx_s1;
			end
		end
	end

	// write-back decision
	always_comb begin
		wb      = '0;
		tgt_idx = '0;
		unique case (action)
			ACT_ADD: begin
				wb.wr_en = 1'b1;
				if (am_found_q)      tgt_idx = am_idx_q;
				else if (fr_found_q) tgt_idx = fr_idx_q;
				else                 tgt_idx = old_idx_q;
			end
			ACT_REMOVE: begin
				wb.wr_en    = ck_found_q;
				wb.wr_clear = 1'b1;
				tgt_idx     = ck_idx_q;
			end
			ACT_REMOVE_ALL: begin
				wb = '0;
			end
			ACT_FIND: begin
				wb.hit = fd_found_q;
			end
		endcase
	end

	// payload only goes out for a find
	assign found_data = (action == ACT_FIND) ? fd_data_q : '0;

endmodule

>>> rtl/core/expiring_challenge_table_top.sv
// top level of the expiring challenge table: sequencer, config register, result register
// depends on ect_pkg, ect_table, ect_scan and expiring_challenge_table_top_defines.svh
//
// channel | signals                    | beat
// --------+----------------------------+--------------------------------------------
// request | req_valid, req_ready, req  | action, cookie, client_ip, payload, time
// result  | rsp_valid, rsp_ready, rsp  | hit, found_data
// config  | cfg_valid, cfg_ready, cfg_data | window in milliseconds
//
// add, remove and find read the slot memory once per slot, then drain the read, write
// back, hand the result over and return to idle to take the next beat.
// remove all sweeps the memory, clearing every slot, then hands its result over.
// after reset a clearing pass over every slot runs before the first request beat.
// a stalled result holds in its register; the next request is taken meanwhile and
// waits at its end until the register frees up.
`include "expiring_challenge_table_top_defines.svh"

module expiring_challenge_table_top #(
	parameter int ENTRIES      = ect_pkg::DEF_ENTRIES,
	parameter int COOKIE_BITS  = ect_pkg::DEF_COOKIE_BITS,
	parameter int PAYLOAD_BITS = ect_pkg::DEF_PAYLOAD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  ect_pkg::ect_req_t            req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output ect_pkg::ect_rsp_t            rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ect_pkg::WINDOW_W-1:0] cfg_data
);
	import ect_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	ect_state_t        state_q, state_d;
	logic [IDX_W-1:0]  cnt_q;
	logic              pend_q;
	ect_req_t          item_q;
	logic [WINDOW_W-1:0] window_q;
	ect_rsp_t          rsp_q;
	logic              rsp_valid_q;

	logic              accept;
	logic              rsp_load;
	logic              rd_en;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [TIME_W-1:0] wr_time;
	logic [COOKIE_BITS-1:0]  wr_cookie;
	logic [ADDR_W-1:0]       wr_addr;
	logic [PAYLOAD_BITS-1:0] wr_payload;
	logic [TIME_W-1:0] now_add;

	logic [TIME_W-1:0]       rd_time;
	logic [COOKIE_BITS-1:0]  rd_cookie;
	logic [ADDR_W-1:0]       rd_addr;
	logic [PAYLOAD_BITS-1:0] rd_payload;

	ect_wb_t                 wb;
	logic [IDX_W-1:0]        tgt_idx;
	logic [PAYLOAD_BITS-1:0] found_data;

	assign accept    = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign now_add   = (item_q.now_ms == '0) ? TIME_W'(1) : item_q.now_ms;

	// window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	// request beat capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
	end

	// state register, slot counter and pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				cnt_q <= IDX_W'(cnt_q + 1'b1);
			end
			if (accept) begin
				pend_q <= 1'b1;
			end else if (rsp_load) begin
				pend_q <= 1'b0;
			end
		end
	end

	// next state, memory control and handshake
	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		rd_en      = 1'b0;
		rsp_load   = 1'b0;
		wr_en      = 1'b0;
		wr_idx     = cnt_q;
		wr_time    = '0;
		wr_cookie  = '0;
		wr_addr    = '0;
		wr_payload = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				if (cnt_q == LAST_IDX) begin
					state_d = pend_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = (req.action == ACT_REMOVE_ALL) ? ST_CLEAR : ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (cnt_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				wr_en  = wb.wr_en;
				wr_idx = tgt_idx;
				if (!wb.wr_clear) begin
					wr_time    = now_add;
					wr_cookie  = item_q.cookie[COOKIE_BITS-1:0];
					wr_addr    = item_q.client_ip;
					wr_payload = item_q.challenge_data[PAYLOAD_BITS-1:0];
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.hit        <= wb.hit;
			rsp_q.found_data <= DATA_W'(found_data);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	ect_table #(
		.ENTRIES      (ENTRIES),
		.COOKIE_BITS  (COOKIE_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_table (
		.clk          (clk),
		.wr_en        (wr_en),
		.wr_idx       (wr_idx),
		.wr_time      (wr_time),
		.wr_cookie    (wr_cookie),
		.wr_addr      (wr_addr),
		.wr_payload   (wr_payload),
		.rd_en        (rd_en),
		.rd_idx       (cnt_q),
		.rd_time_q    (rd_time),
		.rd_cookie_q  (rd_cookie),
		.rd_addr_q    (rd_addr),
		.rd_payload_q (rd_payload)
	);

	ect_scan #(
		.ENTRIES      (ENTRIES),
		.COOKIE_BITS  (COOKIE_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (accept),
		.action       (item_q.action),
		.cookie       (item_q.cookie[COOKIE_BITS-1:0]),
		.addr         (item_q.client_ip),
		.now_find     (item_q.now_ms),
		.now_add      (now_add),
		.window       (window_q),
		.rd_en        (rd_en),
		.rd_idx       (cnt_q),
		.rd_time      (rd_time),
		.rd_cookie    (rd_cookie),
		.rd_addr      (rd_addr),
		.rd_payload   (rd_payload),
		.wb           (wb),
		.tgt_idx      (tgt_idx),
		.found_data   (found_data)
	);

	// checks
	`ECT_ASSERT_NEXT(a_accept_starts_work, clk, arst_n, accept, state_q == ST_SCAN || state_q == ST_CLEAR, "accepted request did not start a scan or sweep")
	`ECT_ASSERT_NOW(a_result_needs_item, clk, arst_n, rsp_load, pend_q, "result loaded with no request in flight")
	`ECT_ASSERT_NOW(a_hit_only_on_find, clk, arst_n, rsp_load && wb.hit, item_q.action == ACT_FIND, "hit reported for an action other than find")

endmodule

>>> test/tb.sv
// testbench of the expiring challenge table: directed and random request beats,
// a scoreboard with its own copy of the slots, random stalls on both sides
// depends on ect_pkg and expiring_challenge_table_top
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ect_pkg::*;

	localparam int SLOTS           = DEF_ENTRIES;
	localparam int SETTLE_CYCLES   = SLOTS + 8;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int PHASE_ITEMS     = 210;
	localparam int PHASES          = 7;
	localparam int HOLD_OFF_AFTER  = 150;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int COOKIE_POOL     = 8;
	localparam int ADDR_POOL       = 24;
	localparam int RECENT_DEPTH    = 16;

	typedef enum int {RX_OPEN, RX_MOSTLY, RX_HALF, RX_PULSE} rx_mode_t;

	// shadow table and queue of expected results of pending requests
	class challenge_table_scoreboard;
		bit [TIME_W-1:0]   slot_time[SLOTS];
		bit [KEY_W-1:0]    slot_cookie[SLOTS];
		bit [ADDR_W-1:0]   slot_addr[SLOTS];
		bit [DATA_W-1:0]   slot_data[SLOTS];
		bit [WINDOW_W-1:0] window = WINDOW_RESET;
		ect_rsp_t          expected_results[$];
		int                mismatches = 0;

		// apply one request to the shadow table, return the lookup result
		function ect_rsp_t apply_request(ect_req_t r);
			ect_rsp_t res;
			bit [TIME_W-1:0] stamp;
			int pick;
			res = '0;
			case (r.action)
			ACT_ADD: begin
				stamp = (r.now_ms == '0) ? TIME_W'(1) : r.now_ms;
				pick = -1;
				// same address first, empty slots included
				for (int i = 0; i < SLOTS && pick < 0; i++)
					if (slot_addr[i] == r.client_ip)
						pick = i;
				// then empty or expired
				for (int i = 0; i < SLOTS && pick < 0; i++)
					if (slot_time[i] == '0 || (stamp - slot_time[i]) > {32'd0, window})
						pick = i;
				// then the first oldest
				if (pick < 0) begin
					pick = 0;
					for (int i = 1; i < SLOTS; i++)
						if (slot_time[i] < slot_time[pick])
							pick = i;
				end
				slot_time[pick]   = stamp;
				slot_cookie[pick] = r.cookie;
				slot_addr[pick]   = r.client_ip;
				slot_data[pick]   = r.challenge_data;
			end
			ACT_REMOVE: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_time[i] != '0 && slot_cookie[i] == r.cookie) begin
						slot_time[i]   = '0;
						slot_cookie[i] = '0;
						slot_addr[i]   = '0;
						slot_data[i]   = '0;
						break;
					end
				end
			end
			ACT_REMOVE_ALL: begin
				for (int i = 0; i < SLOTS; i++) begin
					slot_time[i]   = '0;
					slot_cookie[i] = '0;
					slot_addr[i]   = '0;
					slot_data[i]   = '0;
				end
			end
			default: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_time[i] != '0 && slot_cookie[i] == r.cookie &&
						slot_addr[i] == r.client_ip &&
						(r.now_ms - slot_time[i]) < {32'd0, window}) begin
						res.hit        = 1'b1;
						res.found_data = slot_data[i];
						break;
					end
				end
			end
			endcase
			return res;
		endfunction

		function void note_request(ect_req_t r);
			expected_results.push_back(apply_request(r));
		endfunction

		function void check_result(ect_rsp_t got);
			ect_rsp_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: result beat with nothing pending: hit=%0b data=%h",
					$time, got.hit, got.found_data);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			if (got.hit !== want.hit) begin
				$display("%0t: hit mismatch: expected %0b, actual %0b",
					$time, want.hit, got.hit);
				mismatches++;
			end
			if (got.found_data !== want.found_data) begin
				$display("%0t: found_data mismatch: expected %h, actual %h",
					$time, want.found_data, got.found_data);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	ect_req_t            req;
	logic                rsp_valid;
	logic                rsp_ready;
	ect_rsp_t            rsp;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [WINDOW_W-1:0] cfg_data;

	challenge_table_scoreboard sb = new;

	int                results_seen = 0;
	int                cycle_count  = 0;
	int                burst_left   = 0;
	bit [KEY_W-1:0]    cookie_pool[COOKIE_POOL];
	bit [ADDR_W-1:0]   addr_pool[ADDR_POOL];
	bit [KEY_W-1:0]    recent_cookie[$];
	bit [ADDR_W-1:0]   recent_addr[$];
	bit [TIME_W-1:0]   clock_ms;
	bit [WINDOW_W-1:0] cur_window = WINDOW_RESET;

	expiring_challenge_table_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			sb.check_result(rsp);
			results_seen++;
		end
	end

	// receiver stalls, with one long hold-off to back up the request side
	initial begin
		rx_mode_t mode;
		int seg_left;
		bit held;
		mode = RX_OPEN;
		seg_left = 0;
		held = 1'b0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_OFF_AFTER) begin
				held = 1'b1;
				rsp_ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			if (seg_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				seg_left = $urandom_range(10, 80);
			end
			seg_left--;
			case (mode)
			RX_OPEN:   rsp_ready = 1'b1;
			RX_MOSTLY: rsp_ready = ($urandom_range(0, 3) != 0);
			RX_HALF:   rsp_ready = ($urandom_range(0, 1) != 0);
			default:   rsp_ready = ((seg_left % 8) < 2);
			endcase
		end
	end

	function automatic bit [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic ect_req_t build_req(ect_action_t a, bit [KEY_W-1:0] c,
		bit [ADDR_W-1:0] ip, bit [DATA_W-1:0] d, bit [TIME_W-1:0] t);
		ect_req_t r;
		r.action         = a;
		r.cookie         = c;
		r.client_ip      = ip;
		r.challenge_data = d;
		r.now_ms         = t;
		return r;
	endfunction

	// offer one request beat, then either keep the burst going or pause
	task automatic send_request(input ect_req_t r);
		int gap;
		req = r;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_valid = 1'b0;
			gap = $urandom_range(1, 25);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end
	endtask

	// window update once all pending results are back
	task automatic write_window(input bit [WINDOW_W-1:0] w);
		req_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data = w;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.window = w;
		cur_window = w;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// fresh keys, addresses and time base for a phase
	task automatic start_phase();
		int roll;
		for (int i = 0; i < COOKIE_POOL; i++)
			cookie_pool[i] = rand64();
		for (int i = 0; i < ADDR_POOL; i++)
			addr_pool[i] = $urandom;
		if ($urandom_range(0, 1) != 0)
			addr_pool[0] = '0;
		if ($urandom_range(0, 2) == 0)
			cookie_pool[0] = '1;
		recent_cookie.delete();
		recent_addr.delete();
		roll = $urandom_range(0, 5);
		if (roll == 0)
			clock_ms = rand64();
		else if (roll == 1)
			clock_ms = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 5000);
		else
			clock_ms = $urandom_range(1, 100000);
	endtask

	// mostly pooled keys so lookups and evictions happen, some noise
	task automatic make_request(output ect_req_t r);
		int unsigned step;
		int pick;
		int roll;
		step = cur_window / 3 + 2;
		roll = $urandom_range(0, 99);
		if (roll < 42)
			r.action = ACT_ADD;
		else if (roll < 82)
			r.action = ACT_FIND;
		else if (roll < 97)
			r.action = ACT_REMOVE;
		else
			r.action = ACT_REMOVE_ALL;
		r.challenge_data = rand64();
		r.cookie = cookie_pool[$urandom_range(0, COOKIE_POOL - 1)];
		r.client_ip = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
		if (r.action != ACT_ADD && recent_cookie.size() > 0 && $urandom_range(0, 2) != 0) begin
			pick = $urandom_range(0, recent_cookie.size() - 1);
			r.cookie = recent_cookie[pick];
			r.client_ip = recent_addr[pick];
		end
		if ($urandom_range(0, 9) == 0)
			r.cookie = rand64();
		if ($urandom_range(0, 19) == 0)
			r.client_ip = $urandom;
		// time mostly moves forward, sometimes zero, stale or wild
		clock_ms += $urandom_range(0, step);
		roll = $urandom_range(0, 99);
		if (roll < 3)
			r.now_ms = '0;
		else if (roll < 5)
			r.now_ms = rand64();
		else if (roll < 10)
			r.now_ms = clock_ms - $urandom_range(0, step);
		else
			r.now_ms = clock_ms;
		if (r.action == ACT_ADD) begin
			recent_cookie.push_back(r.cookie);
			recent_addr.push_back(r.client_ip);
			if (recent_cookie.size() > RECENT_DEPTH) begin
				void'(recent_cookie.pop_front());
				void'(recent_addr.pop_front());
			end
		end
	endtask

	// main sequence
	initial begin
		bit [WINDOW_W-1:0] phase_windows[PHASES];
		ect_req_t r;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		phase_windows = '{32'd1, 32'd0, 32'd50, 32'd1000, 32'hFFFF_FFFF, 32'd30000, 32'd0};
		phase_windows[PHASES - 1] = $urandom_range(2, 100000);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed beats under the reset window
		send_request(build_req(ACT_FIND, '0, '0, '0, 64'd10));
		send_request(build_req(ACT_ADD, 64'hA5A5_5A5A_0F0F_F0F0, 32'hC0A8_0001,
			64'h0123_4567_89AB_CDEF, '0));
		send_request(build_req(ACT_FIND, 64'hA5A5_5A5A_0F0F_F0F0, 32'hC0A8_0001, '0, '0));
		send_request(build_req(ACT_FIND, 64'hA5A5_5A5A_0F0F_F0F0, 32'hC0A8_0001, '0,
			64'd30000));
		send_request(build_req(ACT_FIND, 64'hA5A5_5A5A_0F0F_F0F0, 32'hC0A8_0001, '0,
			64'd30001));
		send_request(build_req(ACT_ADD, '1, '0, '1, '1));
		send_request(build_req(ACT_FIND, '1, '0, '0, '1));
		send_request(build_req(ACT_ADD, 64'h1234, 32'hC0A8_0001, 64'hFEED_F00D, 64'd100));
		send_request(build_req(ACT_REMOVE, 64'hA5A5_5A5A_0F0F_F0F0, '0, '0, 64'd150));
		send_request(build_req(ACT_REMOVE, 64'h1234, '0, '0, 64'd200));
		// fill every free slot, then force an oldest-slot replacement
		for (int i = 0; i < SLOTS - 1; i++)
			send_request(build_req(ACT_ADD, 64'(i + 1), 32'h0A00_0000 + i + 1,
				rand64(), 64'd1000 + i));
		send_request(build_req(ACT_ADD, 64'h77, 32'h0B00_0000, rand64(), 64'd1100));
		send_request(build_req(ACT_FIND, 64'd1, 32'h0A00_0001, '0, 64'd1101));
		send_request(build_req(ACT_REMOVE_ALL, rand64(), $urandom, rand64(), rand64()));

		// random phases over several windows
		for (int p = 0; p < PHASES; p++) begin
			write_window(phase_windows[p]);
			start_phase();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				make_request(r);
				send_request(r);
			end
		end

		// drain
		req_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ect_pkg.sv
rtl/core/ect_table.sv
rtl/core/ect_scan.sv
rtl/core/expiring_challenge_table_top.sv
test/tb.sv
